// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top RTL file of the memory unit.
// Depends on nothing; simulation builds get checks, synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk_sig, rst_sig, prop) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk_sig, rst_sig, cond) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk_sig, rst_sig, prop)
`define ASSERT_NEVER(lbl, clk_sig, rst_sig, cond)
`endif
`endif

// ----- rtl/mulu_pkg.sv -----
// Shared types, codes and constants of the multicycle memory unit.
// Used by mulu_ctrl, mulu_dp and memory_unit_with_latency_unit.
package mulu_pkg;

  localparam int WORD_W = 32;
  localparam int DEF_MEM_DEPTH = 256;

  // address reduction: quotient estimate, then remainder with one correction
  localparam int ADDR_STEPS = 2;
  localparam int STEP_W = $clog2(ADDR_STEPS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ADDR_STEPS - 1);

  localparam logic [WORD_W-1:0] ALL_ONES = '1;

  localparam logic CMD_ISSUE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [1:0] OPC_LOAD = 2'd0;
  localparam logic [1:0] OPC_LOADI = 2'd1;
  localparam logic [1:0] OPC_STORE = 2'd2;
  localparam logic [1:0] OPC_STOREV = 2'd3;

  typedef struct packed {
    logic issue;
    logic addr_step;
    logic clear_step;
    logic complete;
    logic clear_hold;
    logic capture;
    logic finished;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic addr_done;
  } dp_stat_t;

  function automatic logic [2:0] op_latency(input logic [1:0] opc);
    logic [2:0] lat;
    unique case (opc)
      OPC_LOAD: lat = 3'd3;
      OPC_LOADI: lat = 3'd1;
      OPC_STORE: lat = 3'd2;
      OPC_STOREV: lat = 3'd2;
      default: lat = 3'd2;
    endcase
    return lat;
  endfunction

endpackage

// ----- rtl/mulu_ctrl.sv -----
// Controller of the memory unit: handshake, countdown and sequencing state.
// Depends on mulu_pkg; drives mulu_dp through ctrl_cmd_t.
module mulu_ctrl
  import mulu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_cmd,
  input  logic [1:0] in_opcode,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_stat_t   stat,
  output ctrl_cmd_t  cmd
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_ADDR = 2'd2;

  localparam logic [2:0] CNT_IDLE = 3'b111;
  localparam logic [2:0] CNT_ZERO = 3'd0;
  localparam logic [2:0] CNT_ONE = 3'd1;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [2:0] cnt;
  logic [2:0] cnt_next;
  logic       accept;

  assign in_stall = (state != ST_IDLE) || (out_valid && out_stall);
  assign accept = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_done) state_next = ST_IDLE;
      end
      ST_ADDR: begin
        cmd.addr_step = 1'b1;
        if (stat.addr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          if (in_cmd == CMD_ISSUE) begin
            cmd.issue = 1'b1;
            cnt_next = op_latency(in_opcode);
            state_next = ST_ADDR;
          end else if (cnt == CNT_ZERO) begin
            cnt_next = CNT_IDLE;
            cmd.clear_hold = 1'b1;
          end else if (cnt != CNT_IDLE) begin
            cnt_next = cnt - 3'd1;
            cmd.complete = (cnt == CNT_ONE);
          end
        end
      end
      default: state_next = ST_CLEAR;
    endcase
    cmd.finished = (cnt_next == CNT_ZERO) || (cnt_next == CNT_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt <= CNT_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      if (accept) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/mulu_dp.sv -----
// Datapath of the memory unit: held instruction, address reduction, data memory, outputs.
// Depends on mulu_pkg; steered by mulu_ctrl through ctrl_cmd_t.
module mulu_dp
  import mulu_pkg::*;
#(
  parameter int MEM_DEPTH = DEF_MEM_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ctrl_cmd_t                cmd,
  output dp_stat_t                 stat,
  input  logic [1:0]               in_opcode,
  input  logic signed [WORD_W-1:0] in_first,
  input  logic signed [WORD_W-1:0] in_second,
  input  logic signed [WORD_W-1:0] in_target,
  output logic signed [WORD_W-1:0] dest_register,
  output logic signed [WORD_W-1:0] result_value,
  output logic                     finished
);

  localparam int AW = $clog2(MEM_DEPTH);
  localparam int RECIP_SHIFT = WORD_W + AW;
  localparam int PROD_W = 2 * WORD_W + 1;
  localparam logic [WORD_W:0] RECIP = (WORD_W + 1)'((64'd1 << RECIP_SHIFT) / MEM_DEPTH);
  localparam logic [AW:0] DEPTH_W = (AW + 1)'(MEM_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(MEM_DEPTH - 1);

  logic [WORD_W-1:0] mem [MEM_DEPTH];
  logic [WORD_W-1:0] rdata;

  logic [1:0]        held_opcode;
  logic [WORD_W-1:0] held_first;
  logic [WORD_W-1:0] held_target;

  logic [WORD_W-1:0] sum_q;
  logic [WORD_W-1:0] quot_q;
  logic [WORD_W-1:0] quot_next;
  logic [PROD_W-1:0] prod;
  logic [AW:0]       rem_prod;
  logic [AW:0]       rem_est;
  logic [AW-1:0]     rem_q;
  logic [AW-1:0]     rem_next;
  logic [STEP_W-1:0] step_q;
  logic [AW-1:0]     clr_idx;
  logic              mem_write;

  assign stat.clear_done = (clr_idx == LAST_IDX);
  assign stat.addr_done = (step_q == STEP_LAST);

  // quotient estimate from the reciprocal: exact or short by one
  assign prod = PROD_W'(sum_q) * PROD_W'(RECIP);
  assign quot_next = WORD_W'(prod >> RECIP_SHIFT);

  // remainder needs only the low bits; one subtract fixes a short quotient
  assign rem_prod = quot_q[AW:0] * DEPTH_W;
  assign rem_est = sum_q[AW:0] - rem_prod;
  assign rem_next = (rem_est >= DEPTH_W) ? AW'(rem_est - DEPTH_W) : rem_est[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      held_opcode <= in_opcode;
      held_first <= in_first;
      held_target <= in_target;
      sum_q <= in_first + in_second;
      rem_q <= '0;
      step_q <= '0;
    end else if (cmd.addr_step) begin
      if (step_q == STEP_LAST) rem_q <= rem_next;
      else quot_q <= quot_next;
      step_q <= step_q + STEP_W'(1);
    end
  end

  assign mem_write = cmd.complete && (held_opcode != OPC_LOAD) && (held_opcode != OPC_LOADI);

  always_ff @(posedge clk) begin
    if (cmd.clear_step) mem[clr_idx] <= '0;
    else if (mem_write) mem[rem_q] <= held_target;
    rdata <= mem[rem_q];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clear_step) begin
      clr_idx <= clr_idx + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_register <= ALL_ONES;
      result_value <= ALL_ONES;
      finished <= 1'b1;
    end else begin
      if (cmd.capture) finished <= cmd.finished;
      if (cmd.clear_hold) begin
        dest_register <= ALL_ONES;
        result_value <= ALL_ONES;
      end else if (cmd.complete) begin
        unique case (held_opcode)
          OPC_LOAD: begin
            dest_register <= held_target;
            result_value <= rdata;
          end
          OPC_LOADI: begin
            dest_register <= held_target;
            result_value <= held_first;
          end
          default: begin
            dest_register <= ALL_ONES;
            result_value <= ALL_ONES;
          end
        endcase
      end
    end
  end

endmodule

// ----- rtl/memory_unit_with_latency_unit.sv -----
// Memory unit with per-opcode latency: after an issue word the unit is busy while the
// address sum is reduced modulo MEM_DEPTH (a quotient estimate by reciprocal multiply,
// then the remainder with one corrective subtract).
// After reset a clearing pass writes zero into the data memory, one word per cycle,
// during which no word is accepted. A word also waits while the previous result is held
// on a stalled output. Loads read the data memory through a registered read port at the
// address left by the issue.
// Depends on mulu_pkg, mulu_ctrl, mulu_dp and assert_macros.svh.
`include "assert_macros.svh"
module memory_unit_with_latency_unit
  import mulu_pkg::*;
#(
  parameter int MEM_DEPTH = DEF_MEM_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     cmd,
  input  logic [1:0]               opcode,
  input  logic signed [WORD_W-1:0] first_operand,
  input  logic signed [WORD_W-1:0] second_operand,
  input  logic signed [WORD_W-1:0] target_or_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [WORD_W-1:0] dest_register,
  output logic signed [WORD_W-1:0] result_value,
  output logic                     finished
);

  ctrl_cmd_t ctl_cmd;
  dp_stat_t  dp_stat;
  logic      in_accept;
  logic      outs_idle;

  assign in_accept = in_valid && !in_stall;
  assign outs_idle = (dest_register == ALL_ONES) && (result_value == ALL_ONES);

  mulu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (cmd),
    .in_opcode (opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (dp_stat),
    .cmd       (ctl_cmd)
  );

  mulu_dp #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (ctl_cmd),
    .stat          (dp_stat),
    .in_opcode     (opcode),
    .in_first      (first_operand),
    .in_second     (second_operand),
    .in_target     (target_or_data),
    .dest_register (dest_register),
    .result_value  (result_value),
    .finished      (finished)
  );

  `ASSERT_CLK(a_complete_finishes, clk, rst, ctl_cmd.complete |=> finished)
  `ASSERT_CLK(a_issue_busy, clk, rst, ctl_cmd.issue |=> !finished)
  `ASSERT_CLK(a_issue_stalls, clk, rst, (in_accept && cmd == CMD_ISSUE) |=> in_stall)
  `ASSERT_CLK(a_idle_clears, clk, rst, ctl_cmd.clear_hold |=> outs_idle)

endmodule

// ----- dv/tb_memory_unit_with_latency_unit.sv -----
`timescale 1ns / 1ps
// Testbench for memory_unit_with_latency_unit: directed and random issue/tick words,
// checked against an in-bench model of the countdown, held operands and data memory.
// Depends on mulu_pkg and the memory_unit_with_latency_unit RTL.
module tb_memory_unit_with_latency_unit
  import mulu_pkg::*;
();

  localparam int DEPTH = DEF_MEM_DEPTH;
  localparam int IDLE_LIMIT = 5000;
  localparam int LONG_HOLD = 200;
  localparam int RANDOM_WORDS = 480;

  typedef struct packed {
    logic [WORD_W-1:0] dest;
    logic [WORD_W-1:0] value;
    logic              fin;
  } unit_output_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic cmd = CMD_TICK;
  logic [1:0] opcode = OPC_LOAD;
  logic signed [WORD_W-1:0] first_operand = '0;
  logic signed [WORD_W-1:0] second_operand = '0;
  logic signed [WORD_W-1:0] target_or_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [WORD_W-1:0] dest_register;
  logic signed [WORD_W-1:0] result_value;
  logic finished;

  // model state of the unit
  logic [WORD_W-1:0] shadow_mem [DEPTH];
  int                countdown;
  logic [1:0]        held_op;
  logic [WORD_W-1:0] held_a, held_b, held_t;
  logic [WORD_W-1:0] reg_hold, val_hold;

  unit_output_t pending_outputs [$];
  int  fail_count = 0;
  int  idle_cycles = 0;
  int  burst_left = 1;
  bit  no_gaps = 0;
  int  hold_requests = 0;
  int  hold_served = 0;
  int  hold_left = 0;
  int  stall_mode = 0;
  int  mode_cycles = 0;

  memory_unit_with_latency_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .opcode(opcode),
    .first_operand(first_operand), .second_operand(second_operand),
    .target_or_data(target_or_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .dest_register(dest_register), .result_value(result_value), .finished(finished)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int op_cycles(input logic [1:0] opc);
    case (opc)
      OPC_LOAD:  return 3;
      OPC_LOADI: return 1;
      default:   return 2;
    endcase
  endfunction

  function automatic unit_output_t next_unit_output(input logic c, input logic [1:0] opc,
                                                    input logic [WORD_W-1:0] a, b, t);
    unit_output_t r;
    logic [WORD_W-1:0] sum;
    if (c == CMD_ISSUE) begin
      held_op = opc;
      held_a = a;
      held_b = b;
      held_t = t;
      countdown = op_cycles(opc);
    end else if (countdown >= 1) begin
      countdown = countdown - 1;
      if (countdown < 1) begin
        sum = held_a + held_b;
        case (held_op)
          OPC_LOAD: begin
            reg_hold = held_t;
            val_hold = shadow_mem[sum % DEPTH];
          end
          OPC_LOADI: begin
            reg_hold = held_t;
            val_hold = held_a;
          end
          default: begin
            shadow_mem[sum % DEPTH] = held_t;
            reg_hold = ALL_ONES;
            val_hold = ALL_ONES;
          end
        endcase
      end
    end else if (countdown == 0) begin
      countdown = -1;
      reg_hold = ALL_ONES;
      val_hold = ALL_ONES;
    end
    r.dest = reg_hold;
    r.value = val_hold;
    r.fin = (countdown < 1);
    return r;
  endfunction

  // predict on each accepted input word first, then check each accepted output word
  always @(posedge clk) begin
    unit_output_t exp_out;
    if (!rst) begin
      if (in_valid && !in_stall)
        pending_outputs.push_back(next_unit_output(cmd, opcode, first_operand,
                                                   second_operand, target_or_data));
      if (out_valid && !out_stall) begin
        if (pending_outputs.size() == 0) begin
          $error("output word with nothing expected");
          fail_count++;
        end else begin
          exp_out = pending_outputs.pop_front();
          if (dest_register !== exp_out.dest) begin
            $error("dest_register: expected %0d, got %0d", $signed(exp_out.dest),
                   dest_register);
            fail_count++;
          end
          if (result_value !== exp_out.value) begin
            $error("result_value: expected %0d, got %0d", $signed(exp_out.value),
                   result_value);
            fail_count++;
          end
          if (finished !== exp_out.fin) begin
            $error("finished: expected %0b, got %0b", exp_out.fin, finished);
            fail_count++;
          end
        end
      end
    end
  end

  // receiver: stall pattern is redrawn at random each time mode_cycles wraps; a long hold overrides it
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_cycles == 63) begin
        stall_mode <= $urandom_range(0, 3);
        mode_cycles <= 0;
      end else begin
        mode_cycles <= mode_cycles + 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 7) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(input logic c, input logic [1:0] opc,
                           input logic [WORD_W-1:0] a, b, t);
    int gap;
    cmd <= c;
    opcode <= opc;
    first_operand <= a;
    second_operand <= b;
    target_or_data <= t;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if (!no_gaps) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_tick();
    send_word(CMD_TICK, 2'($urandom), $urandom, $urandom, $urandom);
  endtask

  task automatic run_op(input logic [1:0] opc, input logic [WORD_W-1:0] a, b, t,
                        input int ticks);
    send_word(CMD_ISSUE, opc, a, b, t);
    repeat (ticks) send_tick();
  endtask

  task automatic test_idle_ticks();
    send_tick();
    send_tick();
  endtask

  task automatic test_each_opcode();
    run_op(OPC_LOADI, 32'h8000_0000, $urandom, 32'h7fff_ffff, 2);
    run_op(OPC_STORE, 32'd3, 32'd4, 32'hffff_ffff, 2);
    run_op(OPC_STOREV, 32'd0, 32'd255, 32'h8000_0000, 3);
    run_op(OPC_LOAD, 32'd7, 32'd0, 32'd0, 3);
  endtask

  task automatic test_address_wrap();
    // the store sum overflows into the sign bit, the load sum wraps to zero; both land on word zero
    run_op(OPC_STORE, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 2);
    run_op(OPC_LOAD, 32'hffff_ffff, 32'd1, 32'h8000_0000, 3);
  endtask

  task automatic test_issue_while_busy();
    // the load restarted by a load immediate never completes
    run_op(OPC_LOAD, 32'hffff_ffff, 32'hffff_ffff, 32'd9, 1);
    run_op(OPC_LOADI, 32'hffff_ffff, 32'd0, 32'd5, 1);
  endtask

  task automatic test_backpressure();
    no_gaps = 1;
    hold_requests <= hold_requests + 1;
    repeat (10) run_op(2'($urandom), $urandom, $urandom_range(0, 15), $urandom, 3);
    no_gaps = 0;
  endtask

  task automatic test_random_mix();
    int words;
    int ticks;
    logic [1:0] opc;
    logic [WORD_W-1:0] a, addr;
    words = 0;
    while (words < RANDOM_WORDS) begin
      if ($urandom_range(0, 99) < 12) begin
        send_word(1'($urandom), 2'($urandom), $urandom, $urandom, $urandom);
      end else begin
        opc = 2'($urandom);
        addr = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 255);
        case ($urandom_range(0, 7))
          0: a = 32'h8000_0000;
          1: a = 32'h7fff_ffff;
          2: a = 32'hffff_ffff;
          3: a = '0;
          default: a = $urandom;
        endcase
        ticks = op_cycles(opc) + $urandom_range(0, 2);
        // cut some sequences short so the next issue lands on a busy unit
        if ($urandom_range(0, 99) < 15) ticks = $urandom_range(0, op_cycles(opc) - 1);
        if ($urandom_range(0, 9) == 0) addr = addr + ($urandom << 8);
        run_op(opc, a, addr - a, $urandom, ticks);
        words += ticks + 1;
      end
    end
  endtask

  initial begin
    foreach (shadow_mem[i]) shadow_mem[i] = '0;
    countdown = -1;
    held_op = OPC_LOAD;
    held_a = '0;
    held_b = '0;
    held_t = '0;
    reg_hold = ALL_ONES;
    val_hold = ALL_ONES;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_idle_ticks();
    test_each_opcode();
    test_address_wrap();
    test_issue_while_busy();
    test_backpressure();
    test_random_mix();
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_outputs.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
